>>> rtl/char_lcd_four_bit_sequencer_top_assert.svh
// assertion macros used by the lcd4_seq module
`ifndef CHAR_LCD_FOUR_BIT_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_FOUR_BIT_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LCD4_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LCD4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lcd4_pkg.sv
// shared types, constants and helpers for the 4-bit lcd sequencer
package lcd4_pkg;

    localparam int HOLD_W  = 17;
    localparam int PULSE_W = 8;
    localparam int PC_W    = 6;

    localparam logic [PC_W-1:0] PC_INIT = 6'd0;
    localparam logic [PC_W-1:0] PC_BYTE = 6'd38;
    localparam logic [PC_W-1:0] PC_LAST = 6'd42;

    localparam logic [HOLD_W-1:0] WAIT_FIRST_US = 17'd10000;
    localparam logic [HOLD_W-1:0] WAIT_RESET_US = 17'd200;
    localparam logic [HOLD_W-1:0] WAIT_MODE_US  = 17'd80;

    localparam logic [HOLD_W-1:0]  RST_POWERUP_US = 17'd100000;
    localparam logic [HOLD_W-1:0]  RST_COMMAND_US = 17'd80;
    localparam logic [HOLD_W-1:0]  RST_GOTO_US    = 17'd100;
    localparam logic [PULSE_W-1:0] RST_PULSE_US   = 8'd1;

    typedef enum logic [1:0] {
        CFG_POWERUP = 2'd0,
        CFG_COMMAND = 2'd1,
        CFG_GOTO    = 2'd2,
        CFG_PULSE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_INSTR = 2'd1,
        CMD_DATA  = 2'd2,
        CMD_GOTO  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        NIB_KEEP,
        NIB_LIT,
        NIB_HI,
        NIB_LO
    } t_nib_sel;

    typedef enum logic [2:0] {
        HOLD_POWERUP,
        HOLD_PULSE,
        HOLD_CMD,
        HOLD_REQ,
        HOLD_FIRST,
        HOLD_RESET,
        HOLD_MODE
    } t_hold_sel;

    // one microcode control word
    typedef struct packed {
        logic      enable;
        t_nib_sel  nib_sel;
        logic [3:0] nib_lit;
        t_hold_sel hold_sel;
        logic      last;
    } t_uword;

    // request decoded at accept time
    typedef struct packed {
        logic              rs;
        logic [7:0]        byte_val;
        logic [HOLD_W-1:0] wait_us;
        logic [PC_W-1:0]   start_pc;
    } t_req;

    typedef struct packed {
        logic [HOLD_W-1:0]  powerup_us;
        logic [HOLD_W-1:0]  command_us;
        logic [PULSE_W-1:0] pulse_us;
    } t_cfg;

    function automatic logic [7:0] row_base(input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd0:    b = 8'h80;
            2'd1:    b = 8'hC0;
            2'd2:    b = 8'h94;
            default: b = 8'hD4;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/lcd4_ucode_rom.sv
// microcode program: init run at step 0, shared byte routine at the byte entry
module lcd4_ucode_rom (
    input  logic [lcd4_pkg::PC_W-1:0] i_pc,
    output lcd4_pkg::t_uword          o_uword
);
    import lcd4_pkg::*;

    function automatic t_uword uw(input logic en, input t_nib_sel ns, input logic [3:0] lit,
                                  input t_hold_sel hs, input logic lst);
        t_uword w;
        w.enable   = en;
        w.nib_sel  = ns;
        w.nib_lit  = lit;
        w.hold_sel = hs;
        w.last     = lst;
        return w;
    endfunction

    always_comb begin
        unique case (i_pc)
            // power-up settle, data lines keep their old levels
            6'd0:  o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_POWERUP, 1'b0);
            // three reset nibbles and the switch to 4-bit mode
            6'd1:  o_uword = uw(1'b1, NIB_LIT,  4'h3, HOLD_PULSE,   1'b0);
            6'd2:  o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd3:  o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_FIRST,   1'b0);
            6'd4:  o_uword = uw(1'b1, NIB_LIT,  4'h3, HOLD_PULSE,   1'b0);
            6'd5:  o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd6:  o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_RESET,   1'b0);
            6'd7:  o_uword = uw(1'b1, NIB_LIT,  4'h3, HOLD_PULSE,   1'b0);
            6'd8:  o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd9:  o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_RESET,   1'b0);
            6'd10: o_uword = uw(1'b1, NIB_LIT,  4'h2, HOLD_PULSE,   1'b0);
            6'd11: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd12: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_MODE,    1'b0);
            // function set 0x28
            6'd13: o_uword = uw(1'b1, NIB_LIT,  4'h2, HOLD_PULSE,   1'b0);
            6'd14: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd15: o_uword = uw(1'b1, NIB_LIT,  4'h8, HOLD_PULSE,   1'b0);
            6'd16: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd17: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_CMD,     1'b0);
            // display off 0x08
            6'd18: o_uword = uw(1'b1, NIB_LIT,  4'h0, HOLD_PULSE,   1'b0);
            6'd19: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd20: o_uword = uw(1'b1, NIB_LIT,  4'h8, HOLD_PULSE,   1'b0);
            6'd21: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd22: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_CMD,     1'b0);
            // clear 0x01
            6'd23: o_uword = uw(1'b1, NIB_LIT,  4'h0, HOLD_PULSE,   1'b0);
            6'd24: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd25: o_uword = uw(1'b1, NIB_LIT,  4'h1, HOLD_PULSE,   1'b0);
            6'd26: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd27: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_CMD,     1'b0);
            // entry mode 0x06
            6'd28: o_uword = uw(1'b1, NIB_LIT,  4'h0, HOLD_PULSE,   1'b0);
            6'd29: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd30: o_uword = uw(1'b1, NIB_LIT,  4'h6, HOLD_PULSE,   1'b0);
            6'd31: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd32: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_CMD,     1'b0);
            // display on 0x0c
            6'd33: o_uword = uw(1'b1, NIB_LIT,  4'h0, HOLD_PULSE,   1'b0);
            6'd34: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd35: o_uword = uw(1'b1, NIB_LIT,  4'hC, HOLD_PULSE,   1'b0);
            6'd36: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd37: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_CMD,     1'b1);
            // byte routine for instruction, data and cursor requests
            6'd38: o_uword = uw(1'b1, NIB_HI,   4'h0, HOLD_PULSE,   1'b0);
            6'd39: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd40: o_uword = uw(1'b1, NIB_LO,   4'h0, HOLD_PULSE,   1'b0);
            6'd41: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE,   1'b0);
            6'd42: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_REQ,     1'b1);
            default: o_uword = uw(1'b0, NIB_KEEP, 4'h0, HOLD_PULSE, 1'b1);
        endcase
    end

endmodule

>>> rtl/lcd4_seq.sv
// step counter, pin latches and output word register driven by the microcode
`include "char_lcd_four_bit_sequencer_top_assert.svh"

module lcd4_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lcd4_pkg::t_req                i_req,
    input  lcd4_pkg::t_cfg                i_cfg,
    output logic [lcd4_pkg::PC_W-1:0]     o_pc,
    input  lcd4_pkg::t_uword              i_uword,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_reg_select,
    output logic                          o_read_write,
    output logic                          o_enable,
    output logic [3:0]                    o_data_nibble,
    output logic [lcd4_pkg::HOLD_W-1:0]   o_hold_us,
    output logic                          o_last
);
    import lcd4_pkg::*;

    logic              r_busy;
    logic [PC_W-1:0]   r_pc;
    logic              r_sel;
    logic [3:0]        r_nib;
    logic [7:0]        r_byte;
    logic [HOLD_W-1:0] r_wait;
    logic              r_out_valid;
    logic              r_out_sel;
    logic              r_out_en;
    logic [3:0]        r_out_nib;
    logic [HOLD_W-1:0] r_out_hold;
    logic              r_out_last;

    logic              w_accept;
    logic              w_load;
    logic [3:0]        n_nib;
    logic [HOLD_W-1:0] n_hold;

    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && !r_busy;
    // while busy, a step retires whenever the output register is free or being emptied
    assign w_load     = r_busy && (!r_out_valid || i_out_ready);
    assign o_pc       = r_pc;

    always_comb begin
        case (i_uword.nib_sel)
            NIB_LIT: n_nib = i_uword.nib_lit;
            NIB_HI:  n_nib = r_byte[7:4];
            NIB_LO:  n_nib = r_byte[3:0];
            default: n_nib = r_nib;
        endcase
    end

    always_comb begin
        case (i_uword.hold_sel)
            HOLD_POWERUP: n_hold = i_cfg.powerup_us;
            HOLD_CMD:     n_hold = i_cfg.command_us;
            HOLD_REQ:     n_hold = r_wait;
            HOLD_FIRST:   n_hold = WAIT_FIRST_US;
            HOLD_RESET:   n_hold = WAIT_RESET_US;
            HOLD_MODE:    n_hold = WAIT_MODE_US;
            default:      n_hold = {{(HOLD_W-PULSE_W){1'b0}}, i_cfg.pulse_us};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_INIT;
            r_sel       <= 1'b0;
            r_nib       <= 4'h0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_pc   <= i_req.start_pc;
                r_sel  <= i_req.rs;
            end
            if (w_load) begin
                r_nib       <= n_nib;
                r_out_valid <= 1'b1;
                if (i_uword.last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pc <= r_pc + 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_req.byte_val;
            r_wait <= i_req.wait_us;
        end
        if (w_load) begin
            r_out_sel  <= r_sel;
            r_out_en   <= i_uword.enable;
            r_out_nib  <= n_nib;
            r_out_hold <= n_hold;
            r_out_last <= i_uword.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_reg_select  = r_out_sel;
    assign o_read_write  = 1'b0;
    assign o_enable      = r_out_en;
    assign o_data_nibble = r_out_nib;
    assign o_hold_us     = r_out_hold;
    assign o_last        = r_out_last;

    `LCD4_ASSERT_NEXT(a_accept_starts, w_accept, r_busy && (r_pc == PC_INIT || r_pc == PC_BYTE), "accept did not start a program")
    `LCD4_ASSERT_NEXT(a_last_ends, w_load && i_uword.last, !r_busy && r_out_valid && r_out_last, "last step did not end the run")
    `LCD4_ASSERT_SAME(a_pc_range, r_busy, r_pc <= PC_LAST, "step counter ran past the program")
    `LCD4_ASSERT_SAME(a_pulse_hold, r_out_valid && r_out_en, r_out_hold == {{(HOLD_W-PULSE_W){1'b0}}, i_cfg.pulse_us}, "enable pulse held wrong time")

endmodule

>>> rtl/char_lcd_four_bit_sequencer_top.sv
// 4-bit character lcd sequencer: config registers, request decode, microcoded sequencer
// an accepted request word is latched first, then its first pin event is loaded into the output register
// throughput: one event per cycle from the microcode step counter while i_out_ready holds; init runs 38 steps,
//   instruction, data and cursor requests run 5 steps of the shared byte routine
// the next request can be accepted in the cycle after the last step is loaded into the output register
// reset (synchronous, active low) clears the sequencer, the rs and data-line latches
//   and loads the default wait and pulse times
module char_lcd_four_bit_sequencer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [lcd4_pkg::HOLD_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_command,
    input  logic [7:0]                  i_value,
    input  logic [5:0]                  i_column,
    input  logic [2:0]                  i_row,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_reg_select,
    output logic                        o_read_write,
    output logic                        o_enable,
    output logic [3:0]                  o_data_nibble,
    output logic [lcd4_pkg::HOLD_W-1:0] o_hold_us,
    output logic                        o_last
);
    import lcd4_pkg::*;

    logic [HOLD_W-1:0]  r_powerup_us;
    logic [HOLD_W-1:0]  r_command_us;
    logic [HOLD_W-1:0]  r_goto_us;
    logic [PULSE_W-1:0] r_pulse_us;

    t_cfg            w_cfg;
    t_req            w_req;
    t_uword          w_uword;
    logic [PC_W-1:0] w_pc;
    logic [1:0]      w_row_sel;
    logic [7:0]      w_goto_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_powerup_us <= RST_POWERUP_US;
            r_command_us <= RST_COMMAND_US;
            r_goto_us    <= RST_GOTO_US;
            r_pulse_us   <= RST_PULSE_US;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POWERUP: r_powerup_us <= i_cfg_data;
                CFG_COMMAND: r_command_us <= i_cfg_data;
                CFG_GOTO:    r_goto_us    <= i_cfg_data;
                CFG_PULSE:   r_pulse_us   <= i_cfg_data[PULSE_W-1:0];
                default:     ;
            endcase
        end
    end

    assign w_cfg.powerup_us = r_powerup_us;
    assign w_cfg.command_us = r_command_us;
    assign w_cfg.pulse_us   = r_pulse_us;

    // row counts from one, only the low two bits pick the ddram base
    assign w_row_sel   = i_row[1:0] - 2'd1;
    assign w_goto_addr = row_base(w_row_sel) + {2'b00, i_column} - 8'd1;

    always_comb begin
        w_req.rs       = 1'b0;
        w_req.byte_val = i_value;
        w_req.wait_us  = r_command_us;
        w_req.start_pc = PC_BYTE;
        unique case (t_cmd'(i_command))
            CMD_INIT:  w_req.start_pc = PC_INIT;
            CMD_INSTR: w_req.rs = 1'b0;
            CMD_DATA:  w_req.rs = 1'b1;
            CMD_GOTO: begin
                w_req.byte_val = w_goto_addr;
                w_req.wait_us  = r_goto_us;
            end
            default:   w_req.rs = 1'b0;
        endcase
    end

    lcd4_ucode_rom u_rom (
        .i_pc    (w_pc),
        .o_uword (w_uword)
    );

    lcd4_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req         (w_req),
        .i_cfg         (w_cfg),
        .o_pc          (w_pc),
        .i_uword       (w_uword),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_reg_select  (o_reg_select),
        .o_read_write  (o_read_write),
        .o_enable      (o_enable),
        .o_data_nibble (o_data_nibble),
        .o_hold_us     (o_hold_us),
        .o_last        (o_last)
    );

endmodule
